/* rtl/modular_exponentiation_assert.svh */
// Assertion macros for the modular exponentiation block.
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// Checked on every rising edge of clk_i while rst_ni is high.
`define ME_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define ME_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/me_pkg.sv */
// Shared constants and types of the modular exponentiation block.
package me_pkg;

  // Width of the words on the channels.
  localparam int FIELD_W = 32;
  // Operand width inside the block; only the low WIDTH bits of each field are used.
  localparam int WIDTH   = 32;
  localparam int PROD_W  = 2 * WIDTH;
  // The reduction retires two product bits per cycle, counting down from WIDTH - 1 to 0.
  localparam int CNT_W   = $clog2(WIDTH);

  typedef struct packed {
    logic start;
  } mm_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_rsp_t;

endpackage

/* rtl/me_if.sv */
// Handshake channels of the modular exponentiation block.
interface me_in_if;
  import me_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] base_value;
  logic [FIELD_W-1:0] exponent_value;
  logic [FIELD_W-1:0] modulus_value;

  modport source (output valid, output base_value, output exponent_value,
                  output modulus_value, input ready);
  modport sink   (input valid, input base_value, input exponent_value,
                  input modulus_value, output ready);
endinterface

interface me_out_if;
  import me_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] power_result;
  logic               zero_modulus_error;

  modport source (output valid, output power_result, output zero_modulus_error,
                  input ready);
  modport sink   (input valid, input power_result, input zero_modulus_error,
                  output ready);
endinterface

/* rtl/me_mulmod.sv */
// Shared modular multiplier: one product, then a two-bit-per-cycle restoring reduction.
module me_mulmod (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  me_pkg::mm_req_t        req_i,
  input  logic [me_pkg::WIDTH-1:0] opa_i,
  input  logic [me_pkg::WIDTH-1:0] opb_i,
  input  logic [me_pkg::WIDTH-1:0] mod_i,
  output me_pkg::mm_rsp_t        rsp_o,
  output logic [me_pkg::WIDTH-1:0] res_o
);
  import me_pkg::*;

  localparam logic [1:0] MM_IDLE = 2'd0;
  localparam logic [1:0] MM_RED  = 2'd1;
  localparam logic [1:0] MM_DONE = 2'd2;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [WIDTH-1:0]  rem_q, rem_d;
  logic [PROD_W-1:0] prod_w;
  logic [WIDTH:0]    mod_ext;
  logic [WIDTH:0]    r1, r2;

  assign prod_w  = PROD_W'(opa_i) * PROD_W'(opb_i);
  assign mod_ext = {1'b0, mod_i};

  // The partial remainder stays below the modulus, so each shifted value is
  // below twice the modulus and one conditional subtract restores it.
  always_comb begin
    r1 = {rem_q, prod_q[PROD_W-1]};
    if (r1 >= mod_ext) begin
      r1 = r1 - mod_ext;
    end
    r2 = {r1[WIDTH-1:0], prod_q[PROD_W-2]};
    if (r2 >= mod_ext) begin
      r2 = r2 - mod_ext;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    prod_d  = prod_q;
    rem_d   = rem_q;
    unique case (state_q)
      MM_IDLE: begin
        if (req_i.start) begin
          prod_d  = prod_w;
          rem_d   = '0;
          cnt_d   = CNT_LAST;
          state_d = MM_RED;
        end
      end
      MM_RED: begin
        prod_d = {prod_q[PROD_W-3:0], 2'b00};
        rem_d  = r2[WIDTH-1:0];
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = MM_DONE;
        end
      end
      MM_DONE: begin
        state_d = MM_IDLE;
      end
      default: begin
        state_d = MM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
  end

  assign rsp_o.busy = (state_q != MM_IDLE);
  assign rsp_o.done = (state_q == MM_DONE);
  assign res_o      = rem_q;

endmodule

/* rtl/modular_exponentiation.sv */
// Top level of the modular exponentiation block: sequencer, operand registers, output word.
//
// Input channel in_i carries a base, an exponent and a modulus; output channel out_o
// returns base**exponent mod modulus and a zero-modulus error flag, one word per input.
// A word is taken when valid and ready are high at a rising edge of clk_i.
// The exponent is scanned from its least significant bit. Every bit below the highest
// set bit costs one squaring, and every set bit one multiply, on a single shared modular
// multiplier. One operation on that unit loads the product, reduces it two bits at a time,
// and then hands the result back from its done state, so an item takes up to two operations
// per exponent bit; a zero exponent or a zero modulus skips the unit.
// A zero modulus returns 0 with the error flag, else a zero exponent returns 1.
// in_i.ready is high only while no item is in work; the next item is taken while a
// finished word still waits in the output register.
// If the receiver stalls, the finished item waits until the output register frees.
// Reset (rst_ni, asynchronous, active low) empties the output register and idles the
// sequencer; nothing else needs clearing.
`include "modular_exponentiation_assert.svh"

module modular_exponentiation (
  input logic clk_i,
  input logic rst_ni,
  me_in_if.sink    in_i,
  me_out_if.source out_o
);
  import me_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_STEP = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_SQR  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [WIDTH-1:0]   base_q, base_d;
  logic [WIDTH-1:0]   exp_q, exp_d;
  logic [WIDTH-1:0]   mod_q, mod_d;
  logic [WIDTH-1:0]   acc_q, acc_d;
  logic               err_q, err_d;
  logic               out_valid_q, out_valid_d;
  logic [FIELD_W-1:0] out_res_q;
  logic               out_err_q;

  logic               in_acc;
  logic               out_ld;
  logic               square;
  logic [WIDTH-1:0]   in_base, in_exp, in_mod;
  logic [WIDTH-1:0]   mm_res;
  mm_req_t            mm_req;
  mm_rsp_t            mm_rsp;

  assign in_base = in_i.base_value[WIDTH-1:0];
  assign in_exp  = in_i.exponent_value[WIDTH-1:0];
  assign in_mod  = in_i.modulus_value[WIDTH-1:0];

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_ld     = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  me_mulmod u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mm_req),
    .opa_i  (square ? base_q : acc_q),
    .opb_i  (base_q),
    .mod_i  (mod_q),
    .rsp_o  (mm_rsp),
    .res_o  (mm_res)
  );

  always_comb begin
    state_d      = state_q;
    base_d       = base_q;
    exp_d        = exp_q;
    mod_d        = mod_q;
    acc_d        = acc_q;
    err_d        = err_q;
    mm_req.start = 1'b0;
    square       = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          base_d = in_base;
          exp_d  = in_exp;
          mod_d  = in_mod;
          err_d  = (in_mod == '0);
          acc_d  = (in_mod == '0) ? '0 : WIDTH'(1);
          if ((in_mod == '0) || (in_exp == '0)) begin
            state_d = S_DONE;
          end else begin
            state_d = S_STEP;
          end
        end
      end
      S_STEP: begin
        mm_req.start = 1'b1;
        if (exp_q[0]) begin
          square  = 1'b0;
          state_d = S_MUL;
        end else begin
          state_d = S_SQR;
        end
      end
      S_MUL: begin
        square = 1'b0;
        if (mm_rsp.done) begin
          acc_d    = mm_res;
          exp_d[0] = 1'b0;
          // The squaring after the top set bit would not change the result.
          if (exp_q[WIDTH-1:1] == '0) begin
            state_d = S_DONE;
          end else begin
            state_d = S_STEP;
          end
        end
      end
      S_SQR: begin
        if (mm_rsp.done) begin
          base_d  = mm_res;
          exp_d   = {1'b0, exp_q[WIDTH-1:1]};
          state_d = S_STEP;
        end
      end
      S_DONE: begin
        if (out_ld) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ld) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    exp_q  <= exp_d;
    mod_q  <= mod_d;
    acc_q  <= acc_d;
    err_q  <= err_d;
    if (out_ld) begin
      out_res_q <= FIELD_W'(acc_q);
      out_err_q <= err_q;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.power_result       = out_res_q;
  assign out_o.zero_modulus_error = out_err_q;

  `ME_ASSERT(a_ready_unit_idle, in_i.ready |-> !mm_rsp.busy, "input ready while unit busy")
  `ME_ASSERT(a_done_when_waiting, mm_rsp.done |-> (state_q == S_MUL || state_q == S_SQR), "unit done with no waiter")
  `ME_ASSERT(a_err_zero_result, (out_o.valid && out_o.zero_modulus_error) |-> (out_o.power_result == '0), "error word with nonzero result")
  `ME_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_o.valid || !$past(rst_ni), "output valid right after reset")

endmodule
